/* rtl/deq_pkg.sv */
// Shared types, constants and helpers for the double-ended queue.
package deq_pkg;

    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_REAR   = 3'd3;
    localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [2:0] CMD_PEEK_REAR  = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] data_in;
    } req_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic [4:0]         fill_count;
        logic               is_empty;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    function automatic idx_t step_up(input idx_t i);
        return (i == idx_t'(CAPACITY - 1)) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t step_down(input idx_t i);
        return (i == '0) ? idx_t'(CAPACITY - 1) : idx_t'(i - 1'b1);
    endfunction

    // Sign-extend (or cut) a stored word to the 32-bit result field.
    function automatic logic signed [31:0] word_to_out(input word_t w);
        logic signed [63:0] ext;
        ext = 64'(signed'(w));
        return ext[31:0];
    endfunction

endpackage

/* rtl/deq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/double_ended_queue.sv */
// Top level of the double-ended queue: ring buffer control around one RAM.
//
// Double-ended queue of signed words held in a ring buffer of CAPACITY entries
// (deq_pkg). Each request transaction carries one command: push front, push
// rear, pop front, pop rear, peek front or peek rear; every request yields
// exactly one response transaction with the word read, a status code, the
// fill count after the operation and an empty flag. Pushes, unused commands
// and pops or peeks on an empty queue are resolved in the cycle the request
// is taken and answered from the output register in the next cycle; the
// next request may follow directly. A pop or peek on a non-empty queue reads
// the entry RAM, whose read data is registered; the response is built in
// ST_READ when the data returns and no request is taken in between. So
// pushes are taken at one request per cycle while the output register drains,
// while reads hold requests off until data returns. The response sits in an
// output register; a new request is taken while that register is empty or
// being drained in the same cycle. Front and rear pointers move at
// acceptance, so a following request always sees the updated queue. Entry
// storage is not cleared at reset; only written slots are ever read.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t state_reg, state_next;
    idx_t   front_reg, front_next;
    idx_t   rear_reg, rear_next;
    cnt_t   count_reg, count_next;
    logic   rsp_valid_reg, rsp_valid_next;
    rsp_t   rsp_reg, rsp_next;

    logic   accept;
    logic   load;
    logic   wr_en;
    idx_t   wr_addr;
    word_t  wr_data;
    logic   rd_en;
    idx_t   rd_addr;
    word_t  rd_data;
    logic   is_full;
    logic   is_zero;

    // Single entry store; pushes write at acceptance, reads return in the next cycle.
    deq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Take a request only with no read in flight and room in the output register.
    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;

    assign is_full = (count_reg == cnt_t'(CAPACITY));
    assign is_zero = (count_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = rear_reg;
        wr_data    = word_t'($unsigned(req.data_in));
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        load       = 1'b0;
        rsp_next   = rsp_reg;

        if (accept)
        begin
            // Most commands answer at once; default to that and override below.
            load                = 1'b1;
            rsp_next.data_out   = '0;
            rsp_next.status     = STATUS_OK;

            case (req.cmd)
                CMD_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        front_next = step_down(front_reg);
                        wr_en      = 1'b1;
                        wr_addr    = step_down(front_reg);
                        count_next = cnt_t'(count_reg + 1'b1);
                    end
                end
                CMD_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = rear_reg;
                        rear_next  = step_up(rear_reg);
                        count_next = cnt_t'(count_reg + 1'b1);
                    end
                end
                CMD_POP_FRONT,
                CMD_POP_REAR,
                CMD_PEEK_FRONT,
                CMD_PEEK_REAR:
                begin
                    if (is_zero)
                    begin
                        rsp_next.data_out = '1;
                        rsp_next.status   = STATUS_EMPTY;
                    end
                    else
                    begin
                        // Issue the read; the response is built when data returns.
                        load       = 1'b0;
                        rd_en      = 1'b1;
                        state_next = ST_READ;
                        if (req.cmd inside {CMD_POP_FRONT, CMD_PEEK_FRONT})
                        begin
                            rd_addr = front_reg;
                        end
                        else
                        begin
                            rd_addr = step_down(rear_reg);
                        end
                        if (req.cmd == CMD_POP_FRONT)
                        begin
                            front_next = step_up(front_reg);
                            count_next = cnt_t'(count_reg - 1'b1);
                        end
                        else if (req.cmd == CMD_POP_REAR)
                        begin
                            rear_next  = step_down(rear_reg);
                            count_next = cnt_t'(count_reg - 1'b1);
                        end
                    end
                end
                default:
                begin
                    // Unused command: report the unchanged queue.
                end
            endcase

            rsp_next.fill_count = 5'(count_next);
            rsp_next.is_empty   = (count_next == '0);
        end
        else if (state_reg == ST_READ)
        begin
            // Read data is back; the count already holds the post-operation value.
            load                = 1'b1;
            state_next          = ST_IDLE;
            rsp_next.data_out   = word_to_out(rd_data);
            rsp_next.status     = STATUS_OK;
            rsp_next.fill_count = 5'(count_reg);
            rsp_next.is_empty   = is_zero;
        end

        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the response payload until a new one is loaded.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
